@@ sv/fmalu_pkg.sv @@
// Shared types and constants for the modular field ALU.
`default_nettype none

package fmalu_pkg;

	// Fixed port field widths
	localparam int DataW     = 32;
	localparam int ReqW      = 2;
	localparam int InTdataW  = 64;
	localparam int OutTdataW = 40;

	// Operation codes carried on the input tuser
	typedef enum logic [ReqW-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Top-level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_EVAL,
		ST_INV,
		ST_MUL,
		ST_DONE
	} state_t;

	// Inverse unit sequencer
	typedef enum logic [2:0] {
		INV_IDLE,
		INV_LOOP,
		INV_ALIGN,
		INV_SUB,
		INV_END
	} inv_state_t;

	// Status from the inverse unit
	typedef struct packed {
		logic done;
		logic ok;
	} inv_status_t;

endpackage

`default_nettype wire

@@ sv/fmalu_inv.sv @@
// Extended Euclid modular inverse, one shift or subtract step per cycle.
`default_nettype none

module fmalu_inv #(
	parameter int WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [WIDTH-1:0]       m,
	input  wire logic [WIDTH-1:0]       b,
	output fmalu_pkg::inv_status_t      status,
	output logic      [WIDTH-1:0]       inv
);

	localparam int W  = WIDTH;
	localparam int TW = WIDTH + 2;      // |t| <= m, partial products <= 2m
	localparam int KW = $clog2(WIDTH);  // shift count 0 .. W-1

	fmalu_pkg::inv_state_t state_q, state_d;

	logic [W-1:0]         m_q, r0_q, r1_q, rem_q, d_q;
	logic signed [TW-1:0] t0_q, t1_q, t2_q, td_q;
	logic [KW-1:0]        k_q;

	logic [W:0]           dd;
	logic                 grow;
	logic                 fits;
	logic [W-1:0]         rem_nx;
	logic signed [TW-1:0] t2_nx;
	logic signed [TW-1:0] t0_pos;

	// quotient digit logic: align divisor up, then subtract down
	assign dd     = {d_q, 1'b0};
	assign grow   = (dd <= {1'b0, rem_q});
	assign fits   = (rem_q >= d_q);
	assign rem_nx = fits ? (rem_q - d_q) : rem_q;
	assign t2_nx  = fits ? (t2_q - td_q) : t2_q;
	assign t0_pos = t0_q + $signed({2'b00, m_q});

	always_comb begin
		status.done = (state_q == fmalu_pkg::INV_END);
		status.ok   = (r0_q == W'(1));
		inv         = t0_q[TW-1] ? t0_pos[W-1:0] : t0_q[W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fmalu_pkg::INV_IDLE:  if (start) state_d = fmalu_pkg::INV_LOOP;
			fmalu_pkg::INV_LOOP: begin
				if (r1_q == '0) state_d = fmalu_pkg::INV_END;
				else            state_d = fmalu_pkg::INV_ALIGN;
			end
			fmalu_pkg::INV_ALIGN: if (!grow) state_d = fmalu_pkg::INV_SUB;
			fmalu_pkg::INV_SUB:   if (k_q == '0) state_d = fmalu_pkg::INV_LOOP;
			fmalu_pkg::INV_END:   state_d = fmalu_pkg::INV_IDLE;
			default:              state_d = fmalu_pkg::INV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmalu_pkg::INV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fmalu_pkg::INV_IDLE: begin
				if (start) begin
					m_q  <= m;
					r0_q <= m;
					r1_q <= b;
					t0_q <= '0;
					t1_q <= TW'(1);
				end
			end
			fmalu_pkg::INV_LOOP: begin
				rem_q <= r0_q;
				d_q   <= r1_q;
				td_q  <= t1_q;
				t2_q  <= t0_q;
				k_q   <= '0;
			end
			fmalu_pkg::INV_ALIGN: begin
				if (grow) begin
					d_q  <= dd[W-1:0];
					td_q <= td_q <<< 1;
					k_q  <= k_q + KW'(1);
				end
			end
			fmalu_pkg::INV_SUB: begin
				rem_q <= rem_nx;
				t2_q  <= t2_nx;
				if (k_q == '0) begin
					// quotient complete: rotate remainders and coefficients
					r0_q <= r1_q;
					r1_q <= rem_nx;
					t0_q <= t1_q;
					t1_q <= t2_nx;
				end else begin
					d_q  <= d_q >> 1;
					td_q <= td_q >>> 1;
					k_q  <= k_q - KW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/modular_field_alu_core.sv @@
// Top level of the modular field ALU: add, subtract, multiply, divide mod a modulus.
`default_nettype none

// Channel    Dir  Handshake            Payload
// s_*        in   s_tvalid/s_tready    tuser: req_type; tdata: operand_a, operand_b
// m_*        out  m_tvalid/m_tready    tuser: no_inverse; tdata: result, eq/lt/gt flags
// cfg_*      in   cfg_we               cfg_wdata: modulus (0 or 1 acts as 2)
//
// Each word runs reduce, then evaluate; add/sub then finish, multiply runs the bit-serial loop;
// the result turns valid in the same cycle that the next word can be taken.
// Divide runs the Euclid inverse, then the same multiply loop with the inverse as
// multiplier; a divisor without inverse skips the multiply.
// Operand reduction is restoring bit-serial, both operands side by side.
// One word is in flight at a time; the result register lets the next word start
// while the previous result is still waiting for m_tready.
// Reset clears the sequencers and the valid flag; modulus resets to 2.

module modular_field_alu_core #(
	parameter int WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// modulus register write
	input  wire logic                               cfg_we,
	input  wire logic [fmalu_pkg::DataW-1:0]        cfg_wdata,
	// input words
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [fmalu_pkg::InTdataW-1:0]     s_tdata,  // operand_a[31:0], operand_b[63:32]
	input  wire logic [fmalu_pkg::ReqW-1:0]         s_tuser,  // req_type[1:0]
	// result words
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [fmalu_pkg::OutTdataW-1:0]         m_tdata,  // result_value[31:0], is_equal[32],
	                                                          // is_less[33], is_greater[34], zero pad
	output logic                                    m_tuser   // no_inverse[0]
);

	localparam int W  = WIDTH;
	localparam int DW = fmalu_pkg::DataW;
	localparam int CW = $clog2(WIDTH + 1);

	fmalu_pkg::state_t state_q, state_d;
	fmalu_pkg::op_t    op_q;

	logic [DW-1:0] modulus_q;

	logic [W-1:0]  m_q;              // effective modulus of the word in flight
	logic [W-1:0]  xa_q, xb_q;       // operand bits, shifted out MSB first
	logic [W-1:0]  ra_q, rb_q;       // reduced operands
	logic [W-1:0]  acc_q, mplier_q;  // bit-serial modular multiply
	logic [W-1:0]  res_q;
	logic          err_q, eq_q, lt_q, gt_q;
	logic [CW-1:0] cnt_q;

	// output register
	logic          m_tvalid_q;
	logic [DW-1:0] out_res_q;
	logic          out_err_q, out_eq_q, out_lt_q, out_gt_q;

	// sequencer outputs
	logic          inv_start;
	logic          out_load;

	// width adaptation between fixed ports and the WIDTH datapath
	logic [W+DW-1:0] a_pad, b_pad, mod_pad, res_pad;
	logic [W-1:0]    m_mask, m_eff;

	// reduction step
	logic [W:0]    ra_sh, rb_sh, ra_sub, rb_sub;
	logic [W-1:0]  ra_nx, rb_nx;

	// add / subtract
	logic [W:0]    sum, sum_red;
	logic [W-1:0]  add_res, diff, sub_res;

	// multiply step: acc = 2*acc + bit*a, then bring below m
	logic [W+1:0]  acc2, acc_s1, acc_s2, m1, m2;
	logic [W-1:0]  acc_nx;

	// inverse unit
	fmalu_pkg::inv_status_t inv_st;
	logic [W-1:0]           inv_val;

	assign a_pad   = {{W{1'b0}}, s_tdata[DW-1:0]};
	assign b_pad   = {{W{1'b0}}, s_tdata[2*DW-1:DW]};
	assign mod_pad = {{W{1'b0}}, modulus_q};
	assign res_pad = {{DW{1'b0}}, res_q};
	assign m_mask  = mod_pad[W-1:0];
	assign m_eff   = (m_mask < W'(2)) ? W'(2) : m_mask;

	// restoring remainder, one operand bit per cycle
	assign ra_sh  = {ra_q, xa_q[W-1]};
	assign rb_sh  = {rb_q, xb_q[W-1]};
	assign ra_sub = ra_sh - {1'b0, m_q};
	assign rb_sub = rb_sh - {1'b0, m_q};
	assign ra_nx  = (ra_sh >= {1'b0, m_q}) ? ra_sub[W-1:0] : ra_sh[W-1:0];
	assign rb_nx  = (rb_sh >= {1'b0, m_q}) ? rb_sub[W-1:0] : rb_sh[W-1:0];

	assign sum     = {1'b0, ra_q} + {1'b0, rb_q};
	assign sum_red = sum - {1'b0, m_q};
	assign add_res = (sum >= {1'b0, m_q}) ? sum_red[W-1:0] : sum[W-1:0];
	assign diff    = ra_q - rb_q;
	assign sub_res = (ra_q < rb_q) ? (diff + m_q) : diff;

	// acc2 < 3m, so one of three candidates is the reduced value
	assign m1     = {2'b00, m_q};
	assign m2     = {1'b0, m_q, 1'b0};
	assign acc2   = {1'b0, acc_q, 1'b0} + (mplier_q[W-1] ? {2'b00, ra_q} : '0);
	assign acc_s1 = acc2 - m1;
	assign acc_s2 = acc2 - m2;
	assign acc_nx = (acc2 >= m2) ? acc_s2[W-1:0] :
	                (acc2 >= m1) ? acc_s1[W-1:0] : acc2[W-1:0];

	fmalu_inv #(
		.WIDTH (WIDTH)
	) u_inv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (inv_start),
		.m      (m_q),
		.b      (rb_q),
		.status (inv_st),
		.inv    (inv_val)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fmalu_pkg::ST_IDLE:   if (s_tvalid) state_d = fmalu_pkg::ST_REDUCE;
			fmalu_pkg::ST_REDUCE: if (cnt_q == CW'(1)) state_d = fmalu_pkg::ST_EVAL;
			fmalu_pkg::ST_EVAL: begin
				unique case (op_q) inside
					fmalu_pkg::OP_ADD, fmalu_pkg::OP_SUB: state_d = fmalu_pkg::ST_DONE;
					fmalu_pkg::OP_MUL:                    state_d = fmalu_pkg::ST_MUL;
					default:                              state_d = fmalu_pkg::ST_INV;
				endcase
			end
			fmalu_pkg::ST_INV: begin
				if (inv_st.done) begin
					state_d = inv_st.ok ? fmalu_pkg::ST_MUL : fmalu_pkg::ST_DONE;
				end
			end
			fmalu_pkg::ST_MUL:    if (cnt_q == CW'(1)) state_d = fmalu_pkg::ST_DONE;
			fmalu_pkg::ST_DONE:   if (out_load) state_d = fmalu_pkg::ST_IDLE;
			default:              state_d = fmalu_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == fmalu_pkg::ST_IDLE);
		inv_start = (state_q == fmalu_pkg::ST_EVAL) && (op_q == fmalu_pkg::OP_DIV);
		out_load  = (state_q == fmalu_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fmalu_pkg::ST_IDLE;
			modulus_q  <= DW'(2);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) modulus_q <= cfg_wdata;
			if (out_load)      m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			fmalu_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					op_q  <= fmalu_pkg::op_t'(s_tuser);
					m_q   <= m_eff;
					xa_q  <= a_pad[W-1:0];
					xb_q  <= b_pad[W-1:0];
					ra_q  <= '0;
					rb_q  <= '0;
					cnt_q <= CW'(W);
				end
			end
			fmalu_pkg::ST_REDUCE: begin
				ra_q  <= ra_nx;
				rb_q  <= rb_nx;
				xa_q  <= xa_q << 1;
				xb_q  <= xb_q << 1;
				cnt_q <= cnt_q - CW'(1);
			end
			fmalu_pkg::ST_EVAL: begin
				eq_q  <= (ra_q == rb_q);
				lt_q  <= (ra_q < rb_q);
				gt_q  <= (ra_q > rb_q);
				err_q <= 1'b0;
				case (op_q)
					fmalu_pkg::OP_ADD: res_q <= add_res;
					fmalu_pkg::OP_SUB: res_q <= sub_res;
					fmalu_pkg::OP_MUL: begin
						acc_q    <= '0;
						mplier_q <= rb_q;
						cnt_q    <= CW'(W);
					end
					default: ;
				endcase
			end
			fmalu_pkg::ST_INV: begin
				if (inv_st.done) begin
					if (inv_st.ok) begin
						// a * b^-1 through the same multiply loop
						acc_q    <= '0;
						mplier_q <= inv_val;
						cnt_q    <= CW'(W);
					end else begin
						res_q <= '0;
						err_q <= 1'b1;
					end
				end
			end
			fmalu_pkg::ST_MUL: begin
				acc_q    <= acc_nx;
				mplier_q <= mplier_q << 1;
				cnt_q    <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) res_q <= acc_nx;
			end
			fmalu_pkg::ST_DONE: begin
				if (out_load) begin
					out_res_q <= res_pad[DW-1:0];
					out_err_q <= err_q;
					out_eq_q  <= eq_q;
					out_lt_q  <= lt_q;
					out_gt_q  <= gt_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_err_q;
	assign m_tdata  = {5'b00000, out_gt_q, out_lt_q, out_eq_q, out_res_q};

endmodule

`default_nettype wire

@@ test/modular_field_alu_core_tb.sv @@
// Self-checking testbench for modular_field_alu_core: directed and random field words.
`timescale 1ns / 100ps

module modular_field_alu_core_tb;

	localparam int DataW     = fmalu_pkg::DataW;
	localparam int ReqW      = fmalu_pkg::ReqW;
	localparam int InTdataW  = fmalu_pkg::InTdataW;
	localparam int OutTdataW = fmalu_pkg::OutTdataW;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 2_000_000; // slowest divide plus gaps and stalls for each of
	                                        // ~570 words, several times over
	localparam int DRAIN_WAIT  = 1000;      // beyond the longest divide latency
	localparam int PHASE_WORDS = 50;
	localparam int PHASES      = 11;

	// One result word, split into its fields
	typedef struct {
		logic [DataW-1:0] value;
		logic             no_inverse;
		logic             is_equal;
		logic             is_less;
		logic             is_greater;
	} field_word_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [DataW-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [InTdataW-1:0]  s_tdata   = '0;  // operand_a[31:0], operand_b[63:32]
	logic [ReqW-1:0]      s_tuser   = '0;  // req_type[1:0]
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OutTdataW-1:0] m_tdata;         // result_value[31:0], is_equal[32], is_less[33],
	                                       // is_greater[34], zero pad
	logic                 m_tuser;         // no_inverse[0]

	// Scoreboard state
	field_word_t      results_due[$];
	logic [DataW-1:0] modulus_shadow = 32'd2;  // tracks the register, reset value 2
	int               words_sent     = 0;
	int               words_checked  = 0;
	int               error_count    = 0;
	int               cycle_count    = 0;
	int               burst_left     = 0;

	// Receiver stall pattern state
	int   ready_mode = 0;
	int   ready_span = 0;
	logic ready_next;

	modular_field_alu_core #(
		.WIDTH(DataW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Extended Euclid on signed 64-bit; Bezout coefficients stay below m in magnitude.
	function automatic bit field_inverse(input logic [63:0] divisor, input logic [63:0] m,
		output logic [63:0] inv);
		longint r_prev, r_cur, t_prev, t_cur, quot, tmp;
		r_prev = m;
		r_cur  = divisor;
		t_prev = 0;
		t_cur  = 1;
		while (r_cur != 0) begin
			quot   = r_prev / r_cur;
			tmp    = r_prev - quot * r_cur;
			r_prev = r_cur;
			r_cur  = tmp;
			tmp    = t_prev - quot * t_cur;
			t_prev = t_cur;
			t_cur  = tmp;
		end
		if (r_prev != 1) begin
			inv = '0;
			return 1'b0;
		end
		t_prev = t_prev % longint'(m);
		if (t_prev < 0)
			t_prev = t_prev + longint'(m);
		inv = t_prev;
		return 1'b1;
	endfunction

	// Expected result word for one request under the given modulus register.
	function automatic field_word_t field_eval(input fmalu_pkg::op_t op,
		input logic [DataW-1:0] a_raw, input logic [DataW-1:0] b_raw,
		input logic [DataW-1:0] mod_reg);
		field_word_t res;
		logic [63:0] m, a, b, inv;
		// a modulus of 0 or 1 acts as 2
		m = (mod_reg < 2) ? 64'd2 : {32'd0, mod_reg};
		a = {32'd0, a_raw} % m;
		b = {32'd0, b_raw} % m;
		res.no_inverse = 1'b0;
		res.is_equal   = (a == b);
		res.is_less    = (a < b);
		res.is_greater = (a > b);
		case (op)
			fmalu_pkg::OP_ADD: res.value = DataW'((a + b) % m);
			fmalu_pkg::OP_SUB: res.value = DataW'((a + m - b) % m);
			fmalu_pkg::OP_MUL: res.value = DataW'((a * b) % m);  // both below 2^32, exact
			default: begin
				if (field_inverse(b, m, inv)) begin
					res.value = DataW'((a * inv) % m);
				end else begin
					res.value      = '0;
					res.no_inverse = 1'b1;
				end
			end
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard: predict on input handshake, compare on output handshake
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		field_word_t due;
		if (cfg_we)
			modulus_shadow = cfg_wdata;
		if (s_tvalid && s_tready)
			results_due.push_back(field_eval(fmalu_pkg::op_t'(s_tuser), s_tdata[31:0],
				s_tdata[63:32], modulus_shadow));
		if (m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$display("%0t unexpected result word: expected none, actual %h / %b",
					$time, m_tdata, m_tuser);
				error_count++;
			end else begin
				due = results_due.pop_front();
				words_checked++;
				if (m_tdata[31:0] !== due.value) begin
					$display("%0t result_value: expected %h, actual %h",
						$time, due.value, m_tdata[31:0]);
					error_count++;
				end
				if (m_tuser !== due.no_inverse) begin
					$display("%0t no_inverse: expected %b, actual %b",
						$time, due.no_inverse, m_tuser);
					error_count++;
				end
				if (m_tdata[32] !== due.is_equal) begin
					$display("%0t is_equal: expected %b, actual %b",
						$time, due.is_equal, m_tdata[32]);
					error_count++;
				end
				if (m_tdata[33] !== due.is_less) begin
					$display("%0t is_less: expected %b, actual %b",
						$time, due.is_less, m_tdata[33]);
					error_count++;
				end
				if (m_tdata[34] !== due.is_greater) begin
					$display("%0t is_greater: expected %b, actual %b",
						$time, due.is_greater, m_tdata[34]);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern changes mode each time its random span runs out
	//   mode 0: always ready, 1: coin flip, 2: one in five, 3: long stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (ready_span == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_span = $urandom_range(20, 300);
		end
		ready_span--;
		case (ready_mode)
			0:       ready_next = 1'b1;
			1:       ready_next = $urandom_range(0, 1);
			2:       ready_next = (cycle_count % 5 == 0);
			default: ready_next = ($urandom_range(0, 31) == 0);
		endcase
		m_tready <= ready_next;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------

	// Send one request word; the sender runs in bursts with random gaps between.
	task automatic send_word(input fmalu_pkg::op_t op, input logic [DataW-1:0] a,
		input logic [DataW-1:0] b);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 2))
				0:       gap = 0;
				1:       gap = $urandom_range(1, 8);
				default: gap = $urandom_range(1, 400);  // lands gaps deep inside a divide
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
		burst_left--;
	endtask

	// Drop valid and wait until every predicted word has come back.
	task automatic drain_results();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (words_checked != words_sent);
	endtask

	// Modulus writes only happen with the block idle.
	task automatic set_modulus(input logic [DataW-1:0] value);
		drain_results();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [DataW-1:0] pick_operand(input logic [DataW-1:0] mod_reg);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'hFFFF_FFFF;
			2:       return mod_reg - 1;
			3:       return mod_reg;
			4:       return mod_reg + DataW'($urandom_range(1, 3));
			5:       return DataW'($urandom_range(0, 15));
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset value of the modulus is 2, no write yet
	task automatic test_reset_modulus();
		send_word(fmalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'd1);
		send_word(fmalu_pkg::OP_SUB, 32'd0, 32'hFFFF_FFFF);
		send_word(fmalu_pkg::OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(fmalu_pkg::OP_DIV, 32'd1, 32'd3);
	endtask

	// Largest 32-bit prime: operand extremes, all ops, all compare outcomes
	task automatic test_operand_extremes();
		set_modulus(32'hFFFF_FFFB);
		send_word(fmalu_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(fmalu_pkg::OP_SUB, 32'd0, 32'hFFFF_FFFA);
		send_word(fmalu_pkg::OP_MUL, 32'hFFFF_FFFA, 32'hFFFF_FFFA);
		send_word(fmalu_pkg::OP_DIV, 32'hFFFF_FFFA, 32'hFFFF_FFFA);
		send_word(fmalu_pkg::OP_ADD, 32'd5, 32'd5);
		send_word(fmalu_pkg::OP_SUB, 32'hFFFF_FFFB, 32'd1);  // left reduces to zero
		send_word(fmalu_pkg::OP_DIV, 32'd9, 32'd0);          // divide by zero
	endtask

	// Composite modulus 3*5*17*257*65537: divisors with and without an inverse
	task automatic test_no_inverse();
		set_modulus(32'hFFFF_FFFF);
		send_word(fmalu_pkg::OP_DIV, 32'd7, 32'd3);
		send_word(fmalu_pkg::OP_DIV, 32'd7, 32'd2);
		send_word(fmalu_pkg::OP_DIV, 32'd7, 32'hFFFF_FFFF);  // divisor reduces to zero
		send_word(fmalu_pkg::OP_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
	endtask

	// Modulus of 0 or 1 acts as 2
	task automatic test_degenerate_modulus();
		set_modulus(32'd0);
		send_word(fmalu_pkg::OP_ADD, 32'd3, 32'd5);
		send_word(fmalu_pkg::OP_DIV, 32'd3, 32'd4);
		set_modulus(32'd1);
		send_word(fmalu_pkg::OP_SUB, 32'd2, 32'd7);
		send_word(fmalu_pkg::OP_DIV, 32'd7, 32'd9);
	endtask

	// Random words over a spread of moduli, one modulus per phase
	task automatic test_random_phases();
		logic [DataW-1:0] mod_reg;
		int phase, n;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       mod_reg = 32'hFFFF_FFFB;
				1:       mod_reg = 32'hFFFF_FFFF;
				2:       mod_reg = 32'd2;
				3:       mod_reg = $urandom_range(3, 255);
				4:       mod_reg = $urandom;
				5:       mod_reg = 32'h8000_0000;
				6:       mod_reg = 32'd0;
				7:       mod_reg = 32'd1;
				8:       mod_reg = 32'd65537;
				9:       mod_reg = $urandom_range(2, 65535);
				default: mod_reg = $urandom | 32'h8000_0000;
			endcase
			set_modulus(mod_reg);
			for (n = 0; n < PHASE_WORDS; n++)
				send_word(fmalu_pkg::op_t'($urandom_range(0, 3)), pick_operand(mod_reg),
					pick_operand(mod_reg));
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_modulus();
		test_operand_extremes();
		test_no_inverse();
		test_degenerate_modulus();
		test_random_phases();

		drain_results();
		// catch any stray word after the last expected one
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0 && results_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/fmalu_pkg.sv
sv/fmalu_inv.sv
sv/modular_field_alu_core.sv
test/modular_field_alu_core_tb.sv
